[hw/rtl/dinucleotide_composition_counter_core_assert.svh]
// assertion macros for the dcc_checker module
`ifndef DINUCLEOTIDE_COMPOSITION_COUNTER_CORE_ASSERT_SVH
`define DINUCLEOTIDE_COMPOSITION_COUNTER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DCC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define DCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/dcc_pkg.sv]
package dcc_pkg;

  localparam int LENGTH_BITS = 24;
  localparam int FRAC_BITS   = 16;
  localparam int NUM_CLASSES = 10;
  localparam int NUM_FRACS   = NUM_CLASSES + 1;
  localparam int IDX_BITS    = $clog2(NUM_FRACS);
  localparam int CLS_BITS    = $clog2(NUM_CLASSES);
  localparam int STEP_BITS   = $clog2(FRAC_BITS + 1);

  typedef logic [LENGTH_BITS-1:0] len_t;
  typedef logic [FRAC_BITS:0]     frac_t;
  typedef logic [2:0]             code_t;
  typedef logic [IDX_BITS-1:0]    idx_t;
  typedef logic [CLS_BITS-1:0]    cls_t;

  localparam frac_t FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam len_t  LEN_MAX  = {LENGTH_BITS{1'b1}};

  // base codes
  localparam code_t CODE_A     = 3'd0;
  localparam code_t CODE_C     = 3'd1;
  localparam code_t CODE_G     = 3'd2;
  localparam code_t CODE_T     = 3'd3;
  localparam code_t CODE_OTHER = 3'd4;
  localparam code_t CODE_NONE  = 3'd7;

  // controller to datapath commands
  typedef struct packed {
    logic count_en;
    logic div_start;
    logic res_wr;
    logic out_load;
    idx_t idx;
  } cmd_t;

  function automatic code_t encode(input logic [7:0] ch);
    code_t c;
    unique case (ch)
      8'h41, 8'h61: c = CODE_A;
      8'h43, 8'h63: c = CODE_C;
      8'h47, 8'h67: c = CODE_G;
      8'h54, 8'h74: c = CODE_T;
      default:      c = CODE_OTHER;
    endcase
    return c;
  endfunction

  // reverse-complement class of a pair, previous base then current base
  function automatic cls_t pair_class(input logic [1:0] prev, input logic [1:0] cur);
    cls_t c;
    unique case ({prev, cur})
      4'b00_00: c = cls_t'(0);
      4'b00_01: c = cls_t'(3);
      4'b00_10: c = cls_t'(2);
      4'b00_11: c = cls_t'(1);
      4'b01_00: c = cls_t'(8);
      4'b01_01: c = cls_t'(4);
      4'b01_10: c = cls_t'(9);
      4'b01_11: c = cls_t'(2);
      4'b10_00: c = cls_t'(5);
      4'b10_01: c = cls_t'(6);
      4'b10_10: c = cls_t'(4);
      4'b10_11: c = cls_t'(3);
      4'b11_00: c = cls_t'(7);
      4'b11_01: c = cls_t'(5);
      4'b11_10: c = cls_t'(8);
      default:  c = cls_t'(0);
    endcase
    return c;
  endfunction

  function automatic len_t sat_inc(input len_t v);
    return (v == LEN_MAX) ? v : v + len_t'(1);
  endfunction

endpackage

[hw/rtl/dcc_div.sv]
module dcc_div
  import dcc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  len_t  num,
  input  len_t  den,
  output logic  done,
  output frac_t quot
);

  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(FRAC_BITS);

  logic [LENGTH_BITS:0]   rem_r, rem_nxt, den_ext, diff, rem_sel;
  len_t                   den_r;
  frac_t                  quot_r, quot_nxt;
  logic [STEP_BITS-1:0]   cnt_r;
  logic                   busy_r, done_r, zero_r, sat_r, qbit;

  // restoring division, one quotient bit a cycle
  assign den_ext  = {1'b0, den_r};
  assign qbit     = (rem_r >= den_ext);
  assign diff     = rem_r - den_ext;
  assign rem_sel  = qbit ? diff : rem_r;
  assign rem_nxt  = {rem_sel[LENGTH_BITS-1:0], 1'b0};
  assign quot_nxt = {quot_r[FRAC_BITS-1:0], qbit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + STEP_BITS'(1);
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {1'b0, num};
      den_r  <= den;
      quot_r <= '0;
      zero_r <= (den == '0);
      sat_r  <= ({1'b0, num} >= {den, 1'b0});
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= quot_nxt;
    end
  end

  assign done = done_r;
  assign quot = zero_r ? '0 : ((sat_r || (quot_r > FRAC_ONE)) ? FRAC_ONE : quot_r);

endmodule

[hw/rtl/dcc_datapath.sv]
module dcc_datapath
  import dcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  input  logic [7:0] base_char,
  output logic       div_done,
  output frac_t      out_frac [NUM_FRACS],
  output len_t       out_len
);

  len_t  len_r, gc_r;
  len_t  pair_r [NUM_CLASSES];
  code_t prev_r, cur_code;
  cls_t  cls, sel;
  frac_t res_r  [NUM_FRACS];
  frac_t outf_r [NUM_FRACS];
  len_t  outl_r;
  len_t  num, den;
  frac_t quot;

  assign cur_code = encode(base_char);
  assign cls      = pair_class(prev_r[1:0], cur_code[1:0]);

  // live read counters
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.out_load) begin
      len_r  <= '0;
      gc_r   <= '0;
      prev_r <= CODE_NONE;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        pair_r[i] <= '0;
      end
    end else if (cmd.count_en) begin
      len_r <= sat_inc(len_r);
      if (cur_code == CODE_C || cur_code == CODE_G) begin
        gc_r <= sat_inc(gc_r);
      end
      if (prev_r < CODE_OTHER && cur_code < CODE_OTHER) begin
        pair_r[cls] <= sat_inc(pair_r[cls]);
      end
      prev_r <= cur_code;
    end
  end

  // operand select: gc over length, then each class over length minus one
  assign sel = CLS_BITS'(cmd.idx - idx_t'(1));
  always_comb begin
    if (cmd.idx == '0) begin
      num = gc_r;
      den = len_r;
    end else begin
      num = pair_r[sel];
      den = len_r - len_t'(1);
    end
  end

  dcc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.res_wr) begin
      res_r[cmd.idx] <= quot;
    end
    if (cmd.out_load) begin
      outf_r <= res_r;
      outl_r <= len_r;
    end
  end

  assign out_frac = outf_r;
  assign out_len  = outl_r;

endmodule

[hw/rtl/dcc_ctrl.sv]
module dcc_ctrl
  import dcc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_end_of_read,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  logic div_done,
  output cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_HAND  = 2'd3;
  localparam idx_t       LAST_IDX = idx_t'(NUM_FRACS - 1);

  logic [1:0] state_r, state_nxt;
  idx_t       k_r, k_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept, slot_free;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && (state_r == S_IDLE);
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    cmd           = '0;
    cmd.idx       = k_r;
    cmd.count_en  = accept;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_end_of_read) begin
          state_nxt = S_START;
          k_nxt     = '0;
        end
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_WAIT;
      end
      S_WAIT: begin
        if (div_done) begin
          cmd.res_wr = 1'b1;
          if (k_r == LAST_IDX) begin
            state_nxt = S_HAND;
          end else begin
            k_nxt     = k_r + idx_t'(1);
            state_nxt = S_START;
          end
        end
      end
      S_HAND: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[hw/rtl/dinucleotide_composition_counter_core.sv]
// channel   direction  payload
// in_       input      base_char (8), end_of_read (1)
// out_      output     gc_fraction and ten pair fractions (17 each), read_len (24)
//
// a base beat is taken every cycle while no read end is being worked out
// a beat with end_of_read holds the input while eleven fractions are worked out,
// each with a start state, the divider's run and a write-back, then the output load
// the finished result sits in an output register; the next read streams in
// while it waits, only the next read end waits for the output slot
// rst_n is synchronous and clears counters, sequencer and out_valid
module dinucleotide_composition_counter_core
  import dcc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_base_char,
  input  logic                   in_end_of_read,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [FRAC_BITS:0]     out_gc_fraction,
  output logic [FRAC_BITS:0]     out_aa_tt_fraction,
  output logic [FRAC_BITS:0]     out_at_fraction,
  output logic [FRAC_BITS:0]     out_ag_ct_fraction,
  output logic [FRAC_BITS:0]     out_ac_gt_fraction,
  output logic [FRAC_BITS:0]     out_gg_cc_fraction,
  output logic [FRAC_BITS:0]     out_ga_tc_fraction,
  output logic [FRAC_BITS:0]     out_gc_pair_fraction,
  output logic [FRAC_BITS:0]     out_ta_fraction,
  output logic [FRAC_BITS:0]     out_tg_ca_fraction,
  output logic [FRAC_BITS:0]     out_cg_fraction,
  output logic [LENGTH_BITS-1:0] out_read_len
);

  // commands from the sequencer, done flag back from the divider
  cmd_t  cmd;
  logic  div_done;
  frac_t out_frac [NUM_FRACS];

  // sequencer: base beats, division order, output slot
  dcc_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_end_of_read (in_end_of_read),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .div_done       (div_done),
    .cmd            (cmd)
  );

  // counters, shared divider and result registers
  dcc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .base_char (in_base_char),
    .div_done  (div_done),
    .out_frac  (out_frac),
    .out_len   (out_read_len)
  );

  // result slots in class order, gc fraction first
  assign out_gc_fraction      = out_frac[0];
  assign out_aa_tt_fraction   = out_frac[1];
  assign out_at_fraction      = out_frac[2];
  assign out_ag_ct_fraction   = out_frac[3];
  assign out_ac_gt_fraction   = out_frac[4];
  assign out_gg_cc_fraction   = out_frac[5];
  assign out_ga_tc_fraction   = out_frac[6];
  assign out_gc_pair_fraction = out_frac[7];
  assign out_ta_fraction      = out_frac[8];
  assign out_tg_ca_fraction   = out_frac[9];
  assign out_cg_fraction      = out_frac[10];

endmodule

[hw/rtl/dcc_checker.sv]
`include "dinucleotide_composition_counter_core_assert.svh"

module dcc_checker
  import dcc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   in_end_of_read,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [FRAC_BITS:0]     out_gc_fraction,
  input logic [FRAC_BITS:0]     out_aa_tt_fraction,
  input logic [FRAC_BITS:0]     out_cg_fraction,
  input logic [LENGTH_BITS-1:0] out_read_len
);

  logic res_held, eor_taken, frac_ok, one_char, no_pairs;

  assign res_held  = out_valid && out_stall;
  assign eor_taken = in_valid && !in_stall && in_end_of_read;
  assign frac_ok   = (out_gc_fraction <= FRAC_ONE) && (out_cg_fraction <= FRAC_ONE);
  assign one_char  = out_valid && (out_read_len == len_t'(1));
  assign no_pairs  = (out_aa_tt_fraction == '0) && (out_cg_fraction == '0);

  `DCC_ASSERT_NEXT(a_out_hold, res_held, out_valid && $stable(out_read_len), "stalled beat moved")
  `DCC_ASSERT_NEXT(a_eor_stalls, eor_taken, in_stall, "input not held after read end")
  `DCC_ASSERT_SAME(a_len_nonzero, out_valid, out_read_len != '0, "result with zero length")
  `DCC_ASSERT_SAME(a_frac_range, out_valid, frac_ok, "fraction above one")
  `DCC_ASSERT_SAME(a_single_char, one_char, no_pairs, "pair fraction on one-character read")

endmodule

bind dinucleotide_composition_counter_core dcc_checker u_dcc_checker (.*);

[bench/dinucleotide_composition_counter_checker.sv]
module dinucleotide_composition_counter_checker
  import dcc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [7:0]             in_base_char,
  input  logic                   in_end_of_read,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [FRAC_BITS:0]     out_gc_fraction,
  input  logic [FRAC_BITS:0]     out_aa_tt_fraction,
  input  logic [FRAC_BITS:0]     out_at_fraction,
  input  logic [FRAC_BITS:0]     out_ag_ct_fraction,
  input  logic [FRAC_BITS:0]     out_ac_gt_fraction,
  input  logic [FRAC_BITS:0]     out_gg_cc_fraction,
  input  logic [FRAC_BITS:0]     out_ga_tc_fraction,
  input  logic [FRAC_BITS:0]     out_gc_pair_fraction,
  input  logic [FRAC_BITS:0]     out_ta_fraction,
  input  logic [FRAC_BITS:0]     out_tg_ca_fraction,
  input  logic [FRAC_BITS:0]     out_cg_fraction,
  input  logic [LENGTH_BITS-1:0] out_read_len,
  output int                     fail_count,
  output int                     results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // reverse-complement pair classes, in result order
  typedef enum int {
    CLS_AA_TT, CLS_AT, CLS_AG_CT, CLS_AC_GT, CLS_GG_CC,
    CLS_GA_TC, CLS_GC, CLS_TA, CLS_TG_CA, CLS_CG
  } pair_cls_e;

  // index 0 is the gc fraction, then the ten pair classes
  typedef struct packed {
    frac_t [NUM_FRACS-1:0] frac;
    len_t                  length;
  } read_summary_t;

  string frac_names [NUM_FRACS] = '{"gc", "aa_tt", "at", "ag_ct", "ac_gt", "gg_cc",
                                    "ga_tc", "gc_pair", "ta", "tg_ca", "cg"};

  read_summary_t expected_reads [$];
  len_t          char_count;
  len_t          gc_bases;
  len_t          class_count [NUM_CLASSES];
  code_t         prev_code;
  int            reads_seen;

  function automatic code_t base_code(input logic [7:0] ch);
    code_t c;
    case (ch)
      "A", "a": c = CODE_A;
      "C", "c": c = CODE_C;
      "G", "g": c = CODE_G;
      "T", "t": c = CODE_T;
      default:  c = CODE_OTHER;
    endcase
    return c;
  endfunction

  // fold a pair onto the lesser of itself and its reverse complement
  function automatic pair_cls_e fold_pair(input code_t prev, input code_t cur);
    logic [3:0] fwd, rev, key;
    pair_cls_e  cls;
    fwd = {prev[1:0], cur[1:0]};
    rev = {~cur[1:0], ~prev[1:0]};
    key = (rev < fwd) ? rev : fwd;
    case (key)
      {CODE_A[1:0], CODE_A[1:0]}: cls = CLS_AA_TT;
      {CODE_A[1:0], CODE_C[1:0]}: cls = CLS_AC_GT;
      {CODE_A[1:0], CODE_G[1:0]}: cls = CLS_AG_CT;
      {CODE_A[1:0], CODE_T[1:0]}: cls = CLS_AT;
      {CODE_C[1:0], CODE_A[1:0]}: cls = CLS_TG_CA;
      {CODE_C[1:0], CODE_C[1:0]}: cls = CLS_GG_CC;
      {CODE_C[1:0], CODE_G[1:0]}: cls = CLS_CG;
      {CODE_G[1:0], CODE_A[1:0]}: cls = CLS_GA_TC;
      {CODE_G[1:0], CODE_C[1:0]}: cls = CLS_GC;
      default:                    cls = CLS_TA;
    endcase
    return cls;
  endfunction

  function automatic len_t bump(input len_t v);
    return (&v) ? v : v + len_t'(1);
  endfunction

  // truncated quotient with 16 fraction bits, clamped at one
  function automatic frac_t ratio(input len_t num, input len_t den);
    logic [63:0] q;
    if (den == '0) return '0;
    q = (64'(num) << FRAC_BITS) / 64'(den);
    return (q > 64'(FRAC_ONE)) ? FRAC_ONE : frac_t'(q);
  endfunction

  task clear_counts();
    char_count = '0;
    gc_bases   = '0;
    for (int k = 0; k < NUM_CLASSES; k++) class_count[k] = '0;
    prev_code  = CODE_NONE;
  endtask

  task report_mismatch(input string what);
    $display("%0t ns mismatch: %s", $time, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    read_summary_t         want;
    frac_t [NUM_FRACS-1:0] got;
    code_t                 code;
    if (!rst_n) begin
      clear_counts();
      expected_reads.delete();
      reads_seen = 0;
      fail_count = 0;
    end else begin
      if (in_valid && !in_stall) begin
        code       = base_code(in_base_char);
        char_count = bump(char_count);
        if (code == CODE_C || code == CODE_G) gc_bases = bump(gc_bases);
        if (prev_code < CODE_OTHER && code < CODE_OTHER)
          class_count[fold_pair(prev_code, code)] = bump(class_count[fold_pair(prev_code, code)]);
        prev_code = code;
        if (in_end_of_read) begin
          want.frac[0] = ratio(gc_bases, char_count);
          for (int k = 0; k < NUM_CLASSES; k++)
            want.frac[1+k] = ratio(class_count[k], char_count - len_t'(1));
          want.length = char_count;
          expected_reads = {expected_reads, want};
          clear_counts();
        end
      end
      if (out_valid && !out_stall) begin
        got = {out_cg_fraction, out_tg_ca_fraction, out_ta_fraction, out_gc_pair_fraction,
               out_ga_tc_fraction, out_gg_cc_fraction, out_ac_gt_fraction,
               out_ag_ct_fraction, out_at_fraction, out_aa_tt_fraction, out_gc_fraction};
        if (expected_reads.size() == 0) begin
          report_mismatch("result beat with no read end waiting");
        end else begin
          want = expected_reads.pop_front();
          for (int k = 0; k < NUM_FRACS; k++)
            if (got[k] !== want.frac[k])
              report_mismatch($sformatf("read %0d %s_fraction got %0d expected %0d",
                                        reads_seen, frac_names[k], got[k], want.frac[k]));
          if (out_read_len !== want.length)
            report_mismatch($sformatf("read %0d length got %0d expected %0d",
                                      reads_seen, out_read_len, want.length));
        end
        reads_seen++;
      end
    end
    results_pending <= expected_reads.size();
  end

endmodule

[bench/dinucleotide_composition_counter_core_test.sv]
module dinucleotide_composition_counter_core_test
  import dcc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // run shape, counted in beats and cycles
  localparam int TARGET_BEATS = 2000;
  localparam int CALM_FROM    = 500;   // no idling on either side in this window
  localparam int CALM_TO      = 800;
  localparam int HOLD_AT      = 1100;  // receiver holds off once from here
  localparam int HOLD_CYCLES  = 1000;  // long enough for a second read end to back up
  localparam int DRAIN_CYCLES = 300;   // a read end takes less than this to work out
  localparam int CYCLE_LIMIT  = 4000000;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [7:0]             in_base_char;
  logic                   in_end_of_read;
  logic                   out_valid;
  logic                   out_stall;
  logic [FRAC_BITS:0]     out_gc_fraction;
  logic [FRAC_BITS:0]     out_aa_tt_fraction;
  logic [FRAC_BITS:0]     out_at_fraction;
  logic [FRAC_BITS:0]     out_ag_ct_fraction;
  logic [FRAC_BITS:0]     out_ac_gt_fraction;
  logic [FRAC_BITS:0]     out_gg_cc_fraction;
  logic [FRAC_BITS:0]     out_ga_tc_fraction;
  logic [FRAC_BITS:0]     out_gc_pair_fraction;
  logic [FRAC_BITS:0]     out_ta_fraction;
  logic [FRAC_BITS:0]     out_tg_ca_fraction;
  logic [FRAC_BITS:0]     out_cg_fraction;
  logic [LENGTH_BITS-1:0] out_read_len;

  int    fail_count;
  int    results_pending;
  int    beats_sent   = 0;
  int    cycle_count  = 0;
  bit    calm         = 1'b0;
  string base_letters = "ACGTacgt";

  dinucleotide_composition_counter_core DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_base_char         (in_base_char),
    .in_end_of_read       (in_end_of_read),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_gc_fraction      (out_gc_fraction),
    .out_aa_tt_fraction   (out_aa_tt_fraction),
    .out_at_fraction      (out_at_fraction),
    .out_ag_ct_fraction   (out_ag_ct_fraction),
    .out_ac_gt_fraction   (out_ac_gt_fraction),
    .out_gg_cc_fraction   (out_gg_cc_fraction),
    .out_ga_tc_fraction   (out_ga_tc_fraction),
    .out_gc_pair_fraction (out_gc_pair_fraction),
    .out_ta_fraction      (out_ta_fraction),
    .out_tg_ca_fraction   (out_tg_ca_fraction),
    .out_cg_fraction      (out_cg_fraction),
    .out_read_len         (out_read_len)
  );

  // watches both channels, predicts every read summary and compares
  dinucleotide_composition_counter_checker composition_check (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_base_char         (in_base_char),
    .in_end_of_read       (in_end_of_read),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_gc_fraction      (out_gc_fraction),
    .out_aa_tt_fraction   (out_aa_tt_fraction),
    .out_at_fraction      (out_at_fraction),
    .out_ag_ct_fraction   (out_ag_ct_fraction),
    .out_ac_gt_fraction   (out_ac_gt_fraction),
    .out_gg_cc_fraction   (out_gg_cc_fraction),
    .out_ga_tc_fraction   (out_ga_tc_fraction),
    .out_gc_pair_fraction (out_gc_pair_fraction),
    .out_ta_fraction      (out_ta_fraction),
    .out_tg_ca_fraction   (out_tg_ca_fraction),
    .out_cg_fraction      (out_cg_fraction),
    .out_read_len         (out_read_len),
    .fail_count           (fail_count),
    .results_pending      (results_pending)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // sender idle length: mostly none, some short, a few long
  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // mostly real bases in either case, some N, the rest any byte at all
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return base_letters[$urandom_range(0, 7)];
    if (r < 88) return (r < 84) ? "N" : "n";
    return 8'($urandom_range(0, 255));
  endfunction

  // read lengths: plenty of single characters and short reads, a few long ones
  function automatic int pick_read_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 1;
    if (r < 85) return $urandom_range(2, 24);
    if (r < 98) return $urandom_range(25, 100);
    return $urandom_range(150, 300);
  endfunction

  // offer one beat and hold it, payload steady, until it is taken
  task automatic send_beat(input logic [7:0] ch, input logic last);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_base_char   <= ch;
    in_end_of_read <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    calm = (beats_sent >= CALM_FROM) && (beats_sent < CALM_TO);
  endtask

  task automatic send_read(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], i == s.len() - 1);
  endtask

  // receiver: random stall pattern, a calm window and one long hold-off
  initial begin : result_sink
    int r;
    int n;
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!held && beats_sent >= HOLD_AT) begin
        // block keeps taking bases until the next read end backs up behind this
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (calm) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_stall <= 1'b0;
          n = $urandom_range(1, 10);
        end else if (r < 92) begin
          out_stall <= 1'b1;
          n = $urandom_range(1, 4);
        end else begin
          out_stall <= 1'b1;
          n = $urandom_range(15, 60);
        end
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin : base_source
    int len;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_base_char   <= 8'h00;
    in_end_of_read <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-character reads: neutral N, a NUL byte, the all-ones byte
    send_beat("N", 1'b1);
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b1);
    // every one of the sixteen ordered pairs once, mixed case
    send_read("AaCAgATcCGcTGgTtA");
    // a neutral character breaks the pair but still counts in the denominator
    send_read("GNc");

    // random reads until the beat budget is spent; the last beat always ends a read
    while (beats_sent < TARGET_BEATS) begin
      len = pick_read_len();
      for (int i = 0; i < len; i++) send_beat(pick_char(), i == len - 1);
    end
    in_valid <= 1'b0;

    // let the checker catch up on the last accepted beat, then drain
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
